/* design/assert_macros.svh */
// Assertion macros used by the RTL of the hasher.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition implies another at the same clock edge.
`define ASSERT_IMPL(label, cond, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`endif

/* design/sha256_pkg.sv */
// Package for the SHA-256 stream hasher: constants, round table and functions.
// Used by the round core, the top level and the testbench; depends on nothing.
package sha256_pkg;

  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 64;
  localparam logic [7:0]  PadMark  = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the sequencer to the round core.
  typedef struct packed {
    logic       start;    // load working variables from chain value
    logic       rnd;      // perform one round this cycle
    logic [5:0] idx;      // round number
    logic       fold;     // add working variables into the chain value
    logic       init;     // return chain value to the initial hash
  } core_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* design/sha256_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sha256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read on one port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/sha256_core.sv */
// Round core: working variables a..h, chain value and message schedule window.
// Depends on sha256_pkg; the block words come from the block RAM read port.
module sha256_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha256_pkg::core_ctl_t ctl_i,
  input  logic [31:0]           wrd_i,     // block word for rounds 0..15
  output logic [255:0]          chain_o    // H0 in the top bits
);
  import sha256_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_cur, w_new, t1, t2, s1, ch, s0, mj;

  // Pick the schedule word: memory for the first sixteen rounds.
  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign w_cur = (ctl_i.idx < 6'd16) ? wrd_i : w_new;

  assign s1 = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + s1 + ch + RoundK[ctl_i.idx] + w_cur;
  assign s0 = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2 = s0 + mj;

  // Hold the chain value; fold or reinitialize on command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // Advance the working variables and the schedule window.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (ctl_i.rnd) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_cur;
    end
  end

  assign chain_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
endmodule

/* design/sha256_stream_hasher_unit.sv */
// Top level of the SHA-256 stream hasher: sequencer, block RAM and round core.
// Depends on sha256_pkg, sha256_ram, sha256_core and assert_macros.svh.
//
// Input channel s_axis: one transaction per item, tdata = data_byte, tuser
// carries byte_valid, tlast is end_of_message. Output channel m_axis: four
// transactions per message, tdata = 64 digest bits, most significant first,
// tlast marks the fourth word.
// A byte is merged into the block word held in a 16x32 RAM by read, modify
// and write back, in the steps accept, read and write. The 64th byte of a
// block starts a compression of 64 rounds, one per cycle, reading the first
// 16 schedule words from the RAM, with a start step before the rounds and a
// fold step after them. End of message pads byte by byte through the same
// path, writes the two length words and compresses once or twice, then emits
// the digest. One item is worked at a time; tready is low meanwhile. Reset
// loads the initial hash value and clears counters; the RAM needs no clearing
// since every byte of a block is written before the rounds read it. A stalled
// receiver holds the digest word in the output register and the block waits.
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_word
  output logic        m_axis_tlast    // word_last
);
  import sha256_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRead  = 9'b000000010,
    StWrite = 9'b000000100,
    StStart = 9'b000001000,
    StRound = 9'b000010000,
    StFold  = 9'b000100000,
    StPad   = 9'b001000000,
    StLen   = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e      st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [7:0]  byte_q, byte_d;
  logic        fin_q, fin_d;     // padding in progress
  logic        lenw_q, lenw_d;   // length words written, final compression
  logic        lsel_q, lsel_d;   // which length word
  logic        padmk_q, padmk_d; // marker byte placed for this message
  logic [6:0]  rnd_q, rnd_d;
  logic [1:0]  oidx_q, oidx_d;
  logic        ovld_q, ovld_d;
  logic [63:0] odat_q, odat_d;
  logic        olst_q, olst_d;

  logic        ram_we;
  logic [3:0]  ram_addr;
  logic [31:0] ram_wdata, ram_rdata, merged;
  logic [63:0] bits;
  logic [255:0] chain;
  core_ctl_t   ctl;
  logic [4:0]  sh;

  sha256_ram #(.Width(32), .Depth(BlkWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sha256_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .wrd_i   (ram_rdata),
    .chain_o (chain)
  );

  assign bits   = {cnt_q, 3'b000};
  assign sh     = {~fill_q[1:0], 3'b000};
  assign merged = (ram_rdata & ~(32'hFF << sh)) | ({24'd0, byte_q} << sh);

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odat_q;
  assign m_axis_tlast  = olst_q;

  // Sequence byte merges, padding, length words, rounds and output words.
  always_comb begin
    st_d = st_q; fill_d = fill_q; cnt_d = cnt_q; byte_d = byte_q;
    fin_d = fin_q; lenw_d = lenw_q; lsel_d = lsel_q; rnd_d = rnd_q;
    padmk_d = padmk_q;
    oidx_d = oidx_q; ovld_d = ovld_q; odat_d = odat_q; olst_d = olst_q;
    ram_we = 1'b0; ram_addr = fill_q[5:2]; ram_wdata = merged;
    ctl = '0;
    ctl.idx = rnd_q[5:0];
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          byte_d = s_axis_tdata;
          fin_d  = s_axis_tlast;
          if (s_axis_tuser) begin
            cnt_d = cnt_q + 61'd1;
            st_d  = StRead;
          end else if (s_axis_tlast) begin
            st_d = StPad;
          end
        end
      end
      StRead: st_d = StWrite;
      StWrite: begin
        ram_we = 1'b1;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) st_d = StStart;
        else if (fin_q) st_d = StPad;
        else st_d = StIdle;
      end
      StPad: begin
        if (padmk_q && fill_q == LenOffset) begin
          lsel_d = 1'b0;
          st_d   = StLen;
        end else begin
          // first padding byte is the marker, then zeros
          byte_d  = padmk_q ? 8'h00 : PadMark;
          padmk_d = 1'b1;
          st_d    = StRead;
        end
      end
      StLen: begin
        ram_we    = 1'b1;
        ram_addr  = lsel_q ? 4'd15 : 4'd14;
        ram_wdata = lsel_q ? bits[31:0] : bits[63:32];
        lsel_d    = 1'b1;
        if (lsel_q) begin
          lenw_d = 1'b1;
          fill_d = 6'd0;
          st_d   = StStart;
        end
      end
      StStart: begin
        ctl.start = 1'b1;
        rnd_d     = 7'd0;
        ram_addr  = 4'd0;
        st_d      = StRound;
      end
      StRound: begin
        ctl.rnd  = 1'b1;
        ram_addr = rnd_q[3:0] + 4'd1;
        rnd_d    = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) st_d = StFold;
      end
      StFold: begin
        ctl.fold = 1'b1;
        if (lenw_q) begin
          oidx_d = 2'd0;
          st_d   = StOut;
        end else if (fin_q) begin
          st_d = StPad;
        end else begin
          st_d = StIdle;
        end
      end
      StOut: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1;
          odat_d = chain[255 - 64*oidx_q -: 64];
          olst_d = (oidx_q == 2'd3);
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            ctl.init = 1'b1;
            cnt_d   = '0;
            fill_d  = '0;
            fin_d   = 1'b0;
            lenw_d  = 1'b0;
            padmk_d = 1'b0;
            st_d    = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fill_q <= '0; cnt_q <= '0; fin_q <= 1'b0; lenw_q <= 1'b0;
      lsel_q <= 1'b0; rnd_q <= '0; oidx_q <= '0; ovld_q <= 1'b0; olst_q <= 1'b0;
      padmk_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; cnt_q <= cnt_d; fin_q <= fin_d;
      lenw_q <= lenw_d; lsel_q <= lsel_d; rnd_q <= rnd_d; oidx_q <= oidx_d;
      ovld_q <= ovld_d; olst_q <= olst_d; padmk_q <= padmk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    odat_q <= odat_d;
  end

  `ASSERT_CLK(a_onehot, $onehot(st_q), clk_i, rst_ni)
  `ASSERT_IMPL(a_out_hold, (ovld_q && !m_axis_tready), ##1 (ovld_q && $stable(odat_q)),
    clk_i, rst_ni)
  `ASSERT_IMPL(a_no_in_busy, (st_q != StIdle), !s_axis_tready, clk_i, rst_ni)
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the SHA-256 stream hasher unit.
// Depends on sha256_pkg for the round constants and initial hash value.
// Feeds byte streams, predicts digests with a local SHA-256 model, checks all words.
module tb_top;
  import sha256_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        word_last;
  } digest_out_t;

  localparam int unsigned WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  msg_item_t   pending_items[$];
  digest_out_t expected_words[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_send = 1'b0;
  bit          stim_done = 1'b0;
  int unsigned error_count = 0;
  int unsigned digest_count = 0;
  int unsigned watch_count = 0;

  // Acceptance seen at the last rising edge
  logic        s_axis_tready_q = 1'b0;
  msg_item_t   accepted_item;

  // Hash state of the predictor
  logic [31:0] hash_state[8];
  logic [31:0] blk_buf[16];
  logic [5:0]  fill_pos;
  logic [60:0] byte_count;

  sha256_stream_hasher_unit u_top (.*);

  // Generate clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = blk_buf[t];
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic append_byte(input logic [7:0] b);
    blk_buf[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_blk();
  endtask

  task automatic reset_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
    fill_pos = '0;
    byte_count = '0;
  endtask

  // Advance the predictor by one accepted item; queue the digest on end of message
  task automatic predict_digest(input msg_item_t it);
    logic [63:0] bits;
    digest_out_t d;
    if (it.byte_valid) begin
      byte_count = byte_count + 61'd1;
      append_byte(it.data_byte);
    end
    if (it.end_of_message) begin
      bits = {byte_count, 3'b000};
      append_byte(PadMark);
      while (fill_pos != LenOffset) append_byte(8'h00);
      blk_buf[14] = bits[63:32];
      blk_buf[15] = bits[31:0];
      compress_blk();
      for (int k = 0; k < 4; k++) begin
        d.digest_word = {hash_state[2*k], hash_state[2*k+1]};
        d.word_last = (k == 3);
        expected_words.insert(expected_words.size(), d);
      end
      reset_hash();
    end
  endtask

  task automatic add_item(input logic [7:0] b, input bit v, input bit e);
    msg_item_t it;
    it = '{data_byte: b, byte_valid: v, end_of_message: e};
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_message(input int unsigned len);
    for (int i = 0; i < len; i++)
      add_item(8'($urandom), 1'b1, (i == len - 1) && ($urandom_range(0, 3) != 0));
    if (len == 0 || pending_items[$].end_of_message == 1'b0)
      add_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  // Drive input transactions at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready_q)) begin
      if (pending_items.size() != 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
      begin
        {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Remember the acceptance seen at the last rising edge
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accepted_item = '{s_axis_tdata, s_axis_tuser, s_axis_tlast};
      predict_digest(accepted_item);
    end
  end

  // Check output transactions and run the watchdog
  always @(posedge clk_i) begin
    digest_out_t exp_w;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        watch_count <= 0;
      else
        watch_count <= watch_count + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.digest_word !== m_axis_tdata || exp_w.word_last !== m_axis_tlast) begin
            $display("%0t: digest mismatch, expected %h last %b, actual %h last %b",
                     $time, exp_w.digest_word, exp_w.word_last, m_axis_tdata, m_axis_tlast);
            error_count++;
          end
          if (exp_w.word_last) digest_count++;
        end
      end
      if (watch_count >= WatchLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_pct[4][2];
    phase_pct = '{'{0, 0}, '{62, 0}, '{0, 62}, '{14, 14}};
    for (int i = 0; i < 16; i++) blk_buf[i] = '0;
    reset_hash();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, idle items, extreme bytes, 55/56/64-byte boundaries
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 55; i++) add_item(8'(i * 37), 1'b1, i == 54);
    for (int i = 0; i < 56; i++) add_item(8'(255 - i), 1'b1, i == 55);
    for (int i = 0; i < 64; i++) add_item(8'(i), 1'b1, i == 63);
    wait_drained();

    // Random short messages over the idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int m = 0; m < 2; m++) begin
        if ($urandom_range(0, 5) == 0) add_item(8'($urandom), 1'b0, 1'b0);
        add_message($urandom_range(0, 8));
      end
      // Wait until all digests are out; in the second phase, then hold the sender on a queued message
      wait_drained();
      hold_send = (p == 1);
      if (hold_send) begin
        add_message(3);
        repeat (50) @(posedge clk_i);
        hold_send = 1'b0;
      end
    end
    wait_drained();
    repeat (400) @(posedge clk_i);

    $display("Covered %0d digests: empty, idle, padding edges and multi-block messages,",
             digest_count);
    $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
